@@ hw/rtl/shbi_pkg.sv @@
// Shared types and constants for the string hash bucket index block.
package shbi_pkg;

  localparam int unsigned ACC_W  = 64;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 24;
  localparam int unsigned BKT_W  = 25;

  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BKT_W-1:0]  bkt_t;

  localparam acc_t  HASH_SEED   = 64'd5381;
  localparam char_t CHAR_END    = 8'd0;
  localparam bkt_t  BKT_RESET   = 25'd65536;
  localparam bkt_t  BKT_MAX     = 25'd16777216;
  localparam bkt_t  BKT_MIN     = 25'd1;

  localparam int unsigned MIX_STEPS = 7;
  localparam logic [2:0]  MIX_LAST  = 3'(MIX_STEPS - 1);
  localparam logic [5:0]  DIV_LAST  = 6'(ACC_W - 1);

endpackage

@@ hw/rtl/shbi_front.sv @@
// Front end: accepts characters and folds them into the djb2 accumulator.
module shbi_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  shbi_pkg::char_t  in_char,
  output logic             q_push,
  output shbi_pkg::acc_t   q_data
);

  shbi_pkg::acc_t acc_r;
  shbi_pkg::acc_t acc_nxt;
  shbi_pkg::acc_t addend;
  logic           is_end;

  assign is_end = (in_char == shbi_pkg::CHAR_END);
  assign addend = {{(shbi_pkg::ACC_W - shbi_pkg::CHAR_W){in_char[shbi_pkg::CHAR_W-1]}}, in_char};

  always_comb begin
    acc_nxt = acc_r;
    if (in_valid) begin
      if (is_end) begin
        acc_nxt = shbi_pkg::HASH_SEED;
      end else begin
        acc_nxt = (acc_r << 5) + acc_r + addend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= shbi_pkg::HASH_SEED;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign q_push = in_valid && is_end;
  assign q_data = acc_r;

endmodule

@@ hw/rtl/shbi_queue.sv @@
// Short queue of finished accumulators between front and back end.
module shbi_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  shbi_pkg::acc_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output shbi_pkg::acc_t  pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  shbi_pkg::acc_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("queue count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not drop on pop");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not rise on push");

endmodule

@@ hw/rtl/shbi_back.sv @@
// Back end: iterative 64-bit mix, bit-serial modulo and result register.
module shbi_back (
  input  logic            clk,
  input  logic            rst_n,
  input  shbi_pkg::bkt_t  bucket_count,
  input  logic            q_empty,
  input  shbi_pkg::acc_t  q_data,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output shbi_pkg::idx_t  bucket_index,
  output shbi_pkg::acc_t  mixed_hash
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [2:0]     step_r, step_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  shbi_pkg::acc_t v_r, v_nxt;
  shbi_pkg::acc_t quo_r, quo_nxt;
  shbi_pkg::bkt_t rem_r, rem_nxt;
  shbi_pkg::bkt_t div_r, div_nxt;
  shbi_pkg::acc_t mix_out;
  shbi_pkg::bkt_t rem_try;
  shbi_pkg::bkt_t div_eff;
  logic           out_valid_r, out_valid_nxt;
  shbi_pkg::idx_t out_idx_r;
  shbi_pkg::acc_t out_hash_r;
  logic           out_load;

  always_comb begin
    if (bucket_count == '0) begin
      div_eff = shbi_pkg::BKT_MIN;
    end else if (bucket_count > shbi_pkg::BKT_MAX) begin
      div_eff = shbi_pkg::BKT_MAX;
    end else begin
      div_eff = bucket_count;
    end
  end

  always_comb begin
    unique case (step_r)
      3'd0:    mix_out = (~v_r) + (v_r << 21);
      3'd1:    mix_out = v_r ^ (v_r >> 24);
      3'd2:    mix_out = v_r + (v_r << 3) + (v_r << 8);
      3'd3:    mix_out = v_r ^ (v_r >> 14);
      3'd4:    mix_out = v_r + (v_r << 2) + (v_r << 4);
      3'd5:    mix_out = v_r ^ (v_r >> 28);
      3'd6:    mix_out = v_r + (v_r << 31);
      default: mix_out = v_r;
    endcase
  end

  // remainder stays below the divisor, so its top bit is free for the shift
  assign rem_try  = {rem_r[shbi_pkg::BKT_W-2:0], quo_r[shbi_pkg::ACC_W-1]};
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || pop);
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    v_nxt         = v_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r;
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          v_nxt     = q_data;
          step_nxt  = '0;
          div_nxt   = div_eff;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        v_nxt    = mix_out;
        step_nxt = step_r + 1'b1;
        if (step_r == shbi_pkg::MIX_LAST) begin
          quo_nxt   = mix_out;
          rem_nxt   = '0;
          cnt_nxt   = shbi_pkg::DIV_LAST;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = quo_r << 1;
        rem_nxt = (rem_try >= div_r) ? rem_try - div_r : rem_try;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    if (out_load) begin
      out_idx_r  <= rem_r[shbi_pkg::IDX_W-1:0];
      out_hash_r <= v_r;
    end
  end

  assign empty        = !out_valid_r;
  assign bucket_index = out_idx_r;
  assign mixed_hash   = out_hash_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_DONE) |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  a_mix_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX) |-> (step_r <= shbi_pkg::MIX_LAST))
    else $error("mix step out of range");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not registered after modulo");

  a_div_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX && step_r == shbi_pkg::MIX_LAST)
      |=> (state_r == ST_DIV && cnt_r == shbi_pkg::DIV_LAST))
    else $error("modulo did not start after mix");

endmodule

@@ hw/rtl/string_hash_bucket_index_top.sv @@
// Top level of the string hash bucket index block.
//
// Characters enter on in_char_byte with push/full; one is taken per cycle
// while full is low. A zero byte ends the word: the djb2 accumulator is
// queued for the back end and restarts at 5381. Non-zero bytes produce no
// result. Each ended word gives one request on the result side with
// out_bucket_index and out_mixed_hash, shown while empty is low and taken
// with pop.
// From the zero byte the accumulator passes through the queue, the iterative
// 64-bit mix and the bit-serial modulo, then the result register.
// Characters stream at one per cycle while full is low. The back end takes
// no new word until the result register has taken the last one.
// A stalled receiver holds the result register; the back end waits, the
// queue fills and then full rises. cfg_wr_en/cfg_wr_data set the bucket
// count (zero acts as one, values above 2^24 as 2^24); write it while idle.
// Reset empties the queue and result register, sets the accumulator to
// 5381 and the bucket count to 65536.
module string_hash_bucket_index_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_char_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic [23:0]           out_bucket_index,
  output logic [63:0]           out_mixed_hash,
  input  logic                  cfg_wr_en,
  input  logic [24:0]           cfg_wr_data
);

  shbi_pkg::bkt_t bucket_count_r;
  logic           in_acc;
  logic           q_push, q_pop, q_empty;
  shbi_pkg::acc_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= shbi_pkg::BKT_RESET;
    end else if (cfg_wr_en) begin
      bucket_count_r <= cfg_wr_data;
    end
  end

  assign in_acc = push && !full;

  shbi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_acc),
    .in_char  (in_char_byte),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  shbi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  shbi_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .bucket_count (bucket_count_r),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .bucket_index (out_bucket_index),
    .mixed_hash   (out_mixed_hash)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for string_hash_bucket_index_top: random words, predicted bucket/hash.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import shbi_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RX_HOLD_CYCLES = 800;
  localparam int QUIET_LIMIT    = 5000;

  typedef struct packed {
    idx_t bucket;
    acc_t hash;
  } bucket_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  char_t       in_char_byte = CHAR_END;
  logic        empty;
  logic        pop = 1'b0;
  idx_t        out_bucket_index;
  acc_t        out_mixed_hash;
  logic        cfg_wr_en = 1'b0;
  bkt_t        cfg_wr_data = '0;

  char_t          char_q[$];
  bucket_result_t bucket_expect_q[$];

  acc_t  djb2_acc;
  bkt_t  bucket_cfg;
  logic  in_taken = 1'b0;
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  int    hold_req = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    quiet_cycles = 0;
  int    mismatches = 0;

  wire in_fire  = push && !full;
  wire out_fire = pop && !empty;

  string_hash_bucket_index_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_char_byte     (in_char_byte),
    .empty            (empty),
    .pop              (pop),
    .out_bucket_index (out_bucket_index),
    .out_mixed_hash   (out_mixed_hash),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic acc_t wang_mix(input acc_t v);
    v = ~v + (v << 21);
    v = v ^ (v >> 24);
    v = v + (v << 3) + (v << 8);
    v = v ^ (v >> 14);
    v = v + (v << 2) + (v << 4);
    v = v ^ (v >> 28);
    v = v + (v << 31);
    return v;
  endfunction

  function automatic idx_t bucket_of(input acc_t h, input bkt_t cnt);
    bkt_t n;
    n = cnt;
    if (n == '0) n = BKT_MIN;
    if (n > BKT_MAX) n = BKT_MAX;
    return idx_t'(h % n);
  endfunction

  function automatic char_t text_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return char_t'(8'h61 + $urandom_range(0, 25));
      6: return char_t'(8'h30 + $urandom_range(0, 42));
      7, 8: return char_t'($urandom_range(1, 255));
      default: return char_t'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input acc_t got, input acc_t want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // request sender: fed from char_q
  always @(negedge clk) begin
    if (!push || in_taken) begin
      if (rst_n && char_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        push <= 1'b1;
        in_char_byte <= char_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= RX_HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // monitor: checks results and runs the hash predictor
  always @(posedge clk) begin : monitor
    bucket_result_t want;
    acc_t           mixed;
    if (!rst_n) begin
      djb2_acc = HASH_SEED;
      bucket_cfg = BKT_RESET;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_fire;
      if (out_fire) begin
        if (bucket_expect_q.size() == 0) begin
          report_mismatch("unexpected result, hash", out_mixed_hash, '0);
        end else begin
          want = bucket_expect_q.pop_front();
          if (out_bucket_index !== want.bucket)
            report_mismatch("bucket_index", acc_t'(out_bucket_index), acc_t'(want.bucket));
          if (out_mixed_hash !== want.hash)
            report_mismatch("mixed_hash", out_mixed_hash, want.hash);
        end
      end
      if (in_fire) begin
        if (in_char_byte != CHAR_END) begin
          djb2_acc = djb2_acc * 64'd33 + {{(ACC_W - CHAR_W){in_char_byte[CHAR_W-1]}}, in_char_byte};
        end else begin
          mixed = wang_mix(djb2_acc);
          bucket_expect_q.push_back('{bucket: bucket_of(mixed, bucket_cfg), hash: mixed});
          djb2_acc = HASH_SEED;
        end
      end
      if (cfg_wr_en) bucket_cfg = cfg_wr_data;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (char_q.size() != 0 || push || bucket_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_buckets(input bkt_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_words(input int n_items, input bit short_only);
    int added;
    int len;
    int pick;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        len = short_only ? $urandom_range(0, 3) : $urandom_range(0, 12);
        repeat (len) char_q.push_back(text_char());
        char_q.push_back(CHAR_END);
        added += len + 1;
      end else if (pick < 17) begin
        // noise, zeros included
        len = $urandom_range(1, 6);
        repeat (len) char_q.push_back(char_t'($urandom_range(0, 255)));
        added += len;
      end else if (pick < 19) begin
        len = $urandom_range(1, 3);
        repeat (len) char_q.push_back(CHAR_END);
        added += len;
      end else begin
        len = $urandom_range(30, 60);
        repeat (len) char_q.push_back(text_char());
        char_q.push_back(CHAR_END);
        added += len + 1;
      end
    end
  endtask

  task automatic run_phase(input bkt_t buckets, input int tx_pct, input int rx_pct,
                           input int n_items, input bit long_hold);
    wait_drained();
    write_buckets(buckets);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (long_hold) hold_req++;
    queue_words(n_items, long_hold);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty word, sign extension edges
    char_q = '{CHAR_END,
               8'h61, CHAR_END,
               8'hFF, CHAR_END,
               8'h80, CHAR_END,
               8'h7F, CHAR_END,
               8'h01, CHAR_END,
               8'hFF, 8'hFF, 8'hFF, CHAR_END,
               8'h55, 8'hAA, CHAR_END};

    run_phase(BKT_MAX, 58, 0, 280, 1'b0);
    run_phase('0, 0, 58, 280, 1'b0);
    run_phase('1, 18, 18, 280, 1'b0);
    run_phase(BKT_MIN, 0, 0, 280, 1'b0);
    run_phase(bkt_t'($urandom_range(2, 16777215)), 58, 58, 280, 1'b0);
    run_phase(bkt_t'(16777215), 0, 0, 280, 1'b1);
    run_phase(bkt_t'(3), 18, 18, 280, 1'b0);
    wait_drained();

    if (mismatches == 0 && bucket_expect_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
